[hdl/clamped_linear_histogram_core_defines.svh]
// Assertion macros shared by the histogram core files.
`ifndef CLAMPED_LINEAR_HISTOGRAM_CORE_DEFINES_SVH
`define CLAMPED_LINEAR_HISTOGRAM_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLH_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("histogram core: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CLH_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("histogram core: next-cycle check failed");

`endif

[hdl/clh_pkg.sv]
`timescale 1ns / 1ps

package clh_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int SLOT_W     = 4;
   localparam int IDX_W      = 10;
   localparam int COUNT_W    = 40;
   localparam int OP_W       = 2;
   localparam int CSR_ADDR_W = 2;

   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 96;
   localparam int RSP_USER_W = 1;

   localparam logic [OP_W-1:0] OP_ACCUM = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] REG_MIN = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_SEL = 2'd2;

   localparam logic [SAMPLE_W-1:0] MIN_RESET = 32'h0000_0000;
   localparam logic [SAMPLE_W-1:0] MAX_RESET = 32'h0001_0000;
   localparam logic [SLOT_W-1:0]   SEL_RESET = 4'h0;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_MUL,
      ST_DSTART,
      ST_DIV,
      ST_FETCH,
      ST_MODIFY,
      ST_WIPE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic decode;
      logic mul;
      logic div_start;
      logic div_step;
      logic modify;
      logic sweep;
      logic resp_load;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            hit;
      logic            need_div;
      logic            sweep_last;
      logic            div_last;
      logic            out_free;
   } status_type;

endpackage

[hdl/clamped_linear_histogram_core.sv]
`timescale 1ns / 1ps
`include "clamped_linear_histogram_core_defines.svh"

// Uniform-bin histogram over signed Q16.16 samples, one item in flight at a
// time. An accumulate item whose sample falls strictly inside the configured
// range passes through decode, multiply, divider start, the divide steps, fetch,
// modify and response; the bin number comes out of a restoring divider that
// yields one quotient bit per cycle. An accumulate item clamped to the first or
// last bin, or a read, skips the multiply and divide; a skipped sample or unused
// op goes straight from decode to response; a clear zeroes the count memory one
// bin per cycle. After reset the same zeroing pass runs before the first item
// is accepted; configuration writes are taken at any time. A finished result
// sits in an output register, and the next item is taken only once that
// register can be loaded.
module clamped_linear_histogram_core #(
   parameter int BIN_COUNT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [clh_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [clh_pkg::SAMPLE_W-1:0]      csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // sample [31:0], component_slot [35:32], read_addr [45:36], zero [47:46]
   input  logic [clh_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op [1:0], sample_finite [2]
   input  logic [clh_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // bin_index [9:0], bin_count [49:10], peak_count [89:50], zero [95:90]
   output logic [clh_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // counted [0]
   output logic [clh_pkg::RSP_USER_W-1:0]    rsp_tuser
);
   import clh_pkg::*;

   localparam int SLOT_LO = SAMPLE_W;
   localparam int ADDR_LO = SAMPLE_W + SLOT_W;
   localparam int RSP_PAD = RSP_DATA_W - (IDX_W + 2 * COUNT_W);

   cmd_type             cmd;
   status_type          status;
   logic [IDX_W-1:0]    bin_index;
   logic [COUNT_W-1:0]  bin_count;
   logic [COUNT_W-1:0]  peak_count;
   logic                counted;

   clh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   clh_datapath #(
      .BIN_COUNT (BIN_COUNT)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_addr           (csr_addr),
      .csr_wdata          (csr_wdata),
      .req_op             (req_tuser[OP_W-1:0]),
      .req_sample         (req_tdata[SAMPLE_W-1:0]),
      .req_sample_finite  (req_tuser[OP_W]),
      .req_component_slot (req_tdata[SLOT_LO +: SLOT_W]),
      .req_read_addr      (req_tdata[ADDR_LO +: IDX_W]),
      .cmd                (cmd),
      .status             (status),
      .rsp_tready         (rsp_tready),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_bin_index      (bin_index),
      .rsp_bin_count      (bin_count),
      .rsp_peak_count     (peak_count),
      .rsp_counted        (counted)
   );

   assign rsp_tdata = {{RSP_PAD{1'b0}}, peak_count, bin_count, bin_index};
   assign rsp_tuser = counted;

   `CLH_ASSERT_NEXT(a_one_item_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)
   `CLH_ASSERT_NOW(a_counted_is_nonzero, clock, reset, rsp_tvalid && counted, (bin_count != '0) && (peak_count >= bin_count))

endmodule

[hdl/clh_ram.sv]
`timescale 1ns / 1ps

module clh_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/clh_ctrl.sv]
`timescale 1ns / 1ps

module clh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output clh_pkg::cmd_type    cmd,
   input  clh_pkg::status_type status
);
   import clh_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (status.op)
               OP_ACCUM: begin
                  if (!status.hit)          state_in = ST_RESP;
                  else if (status.need_div) state_in = ST_MUL;
                  else                      state_in = ST_FETCH;
               end
               OP_READ:  state_in = ST_FETCH;
               OP_CLEAR: state_in = ST_WIPE;
               default:  state_in = ST_RESP;
            endcase
         end
         ST_MUL:    state_in = ST_DSTART;
         ST_DSTART: state_in = ST_DIV;
         ST_DIV: begin
            if (status.div_last) state_in = ST_FETCH;
         end
         ST_FETCH:  state_in = ST_MODIFY;
         ST_MODIFY: state_in = ST_RESP;
         ST_WIPE: begin
            if (status.sweep_last) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_INIT;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_INIT:   cmd.sweep = 1'b1;
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_DECODE: cmd.decode    = 1'b1;
         ST_MUL:    cmd.mul       = 1'b1;
         ST_DSTART: cmd.div_start = 1'b1;
         ST_DIV:    cmd.div_step  = 1'b1;
         ST_FETCH:  cmd           = '0;
         ST_MODIFY: cmd.modify    = 1'b1;
         ST_WIPE:   cmd.sweep     = 1'b1;
         ST_RESP:   cmd.resp_load = status.out_free;
         default:   cmd           = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/clh_datapath.sv]
`timescale 1ns / 1ps
`include "clamped_linear_histogram_core_defines.svh"

module clh_datapath #(
   parameter int BIN_COUNT = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [clh_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [clh_pkg::SAMPLE_W-1:0]       csr_wdata,
   input  logic [clh_pkg::OP_W-1:0]           req_op,
   input  logic [clh_pkg::SAMPLE_W-1:0]       req_sample,
   input  logic                               req_sample_finite,
   input  logic [clh_pkg::SLOT_W-1:0]         req_component_slot,
   input  logic [clh_pkg::IDX_W-1:0]          req_read_addr,
   input  clh_pkg::cmd_type                   cmd,
   output clh_pkg::status_type                status,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [clh_pkg::IDX_W-1:0]          rsp_bin_index,
   output logic [clh_pkg::COUNT_W-1:0]        rsp_bin_count,
   output logic [clh_pkg::COUNT_W-1:0]        rsp_peak_count,
   output logic                               rsp_counted
);
   import clh_pkg::*;

   localparam int AW = $clog2(BIN_COUNT);
   localparam int XW = AW + IDX_W;
   localparam int NW = SAMPLE_W + AW;
   localparam int SW = $clog2(AW + 1);
   localparam int DW = SAMPLE_W + 1;
   localparam logic [AW-1:0] TOP_BIN = AW'(BIN_COUNT - 1);

   // Configuration registers.
   logic [SAMPLE_W-1:0] min_ff, min_in;
   logic [SAMPLE_W-1:0] max_ff, max_in;
   logic [SLOT_W-1:0]   sel_ff, sel_in;

   // Item registers.
   logic [OP_W-1:0]     op_ff, op_in;
   logic                hit_ff, hit_in;
   logic                rd_ok_ff, rd_ok_in;
   logic [IDX_W-1:0]    rd_addr_ff, rd_addr_in;
   logic [AW-1:0]       bin_ff, bin_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic signed [DW-1:0] diff_ff, diff_in;
   logic signed [DW-1:0] span_ff, span_in;
   logic [NW-1:0]       num_ff, num_in;
   logic [SAMPLE_W-1:0] rem_ff, rem_in;
   logic [SW-1:0]       step_ff, step_in;
   logic [AW-1:0]       sweep_ff, sweep_in;
   logic [COUNT_W-1:0]  peak_ff, peak_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [COUNT_W-1:0]  rsp_peak_ff, rsp_peak_in;
   logic                rsp_counted_ff, rsp_counted_in;

   logic signed [DW-1:0] samp_x, min_x, max_x;
   logic                low_case, high_case;
   logic [SAMPLE_W:0]   trial, span_u, trial_sub;
   logic                take;
   logic [AW:0]         quot_shift;
   logic [XW-1:0]       addr_wide, bin_wide;
   logic                sweep_last;
   logic                out_free;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [COUNT_W-1:0]  ram_wdata, ram_rdata, inc_cnt;

   assign samp_x = {req_sample[SAMPLE_W-1], req_sample};
   assign min_x  = {min_ff[SAMPLE_W-1], min_ff};
   assign max_x  = {max_ff[SAMPLE_W-1], max_ff};

   // Empty range or sample at/below the lower edge lands in bin 0; at or past
   // the upper edge it is clamped to the top bin without dividing.
   assign low_case  = span_ff[DW-1] || (span_ff == '0) || diff_ff[DW-1] || (diff_ff == '0);
   assign high_case = !low_case && (diff_ff >= span_ff);

   // One restoring-division step: the quotient bits shift into bin_ff while
   // the low dividend bits shift out of it.
   assign trial      = {rem_ff, bin_ff[AW-1]};
   assign span_u     = {1'b0, span_ff[SAMPLE_W-1:0]};
   assign take       = (trial >= span_u);
   assign trial_sub  = trial - span_u;
   assign quot_shift = {bin_ff, take};

   assign addr_wide  = XW'(req_read_addr);
   assign bin_wide   = XW'(bin_ff);
   assign sweep_last = (sweep_ff == TOP_BIN);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign inc_cnt = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_W'(1);

   assign ram_we    = cmd.sweep || (cmd.modify && (op_ff == OP_ACCUM));
   assign ram_waddr = cmd.sweep ? sweep_ff : bin_ff;
   assign ram_wdata = cmd.sweep ? '0 : inc_cnt;

   clh_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (BIN_COUNT)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (bin_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      min_in         = min_ff;
      max_in         = max_ff;
      sel_in         = sel_ff;
      op_in          = op_ff;
      hit_in         = hit_ff;
      rd_ok_in       = rd_ok_ff;
      rd_addr_in     = rd_addr_ff;
      bin_in         = bin_ff;
      cnt_in         = cnt_ff;
      diff_in        = diff_ff;
      span_in        = span_ff;
      num_in         = num_ff;
      rem_in         = rem_ff;
      step_in        = step_ff;
      sweep_in       = sweep_ff;
      peak_in        = peak_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_peak_in    = rsp_peak_ff;
      rsp_counted_in = rsp_counted_ff;

      if (csr_we) begin
         unique case (csr_addr)
            REG_MIN: min_in = csr_wdata;
            REG_MAX: max_in = csr_wdata;
            REG_SEL: sel_in = csr_wdata[SLOT_W-1:0];
            default: sel_in = sel_ff;
         endcase
      end

      if (cmd.load) begin
         op_in      = req_op;
         hit_in     = (req_op == OP_ACCUM) && req_sample_finite
                      && (req_component_slot == sel_ff);
         rd_ok_in   = (addr_wide < XW'(BIN_COUNT));
         rd_addr_in = req_read_addr;
         bin_in     = (req_op == OP_READ) ? addr_wide[AW-1:0] : '0;
         cnt_in     = '0;
         diff_in    = samp_x - min_x;
         span_in    = max_x - min_x;
      end

      if (cmd.decode && hit_ff) begin
         if (low_case)       bin_in = '0;
         else if (high_case) bin_in = TOP_BIN;
      end

      if (cmd.mul) begin
         num_in = NW'(diff_ff[SAMPLE_W-1:0]) * NW'(BIN_COUNT);
      end

      if (cmd.div_start) begin
         rem_in  = num_ff[NW-1:AW];
         bin_in  = num_ff[AW-1:0];
         step_in = '0;
      end

      if (cmd.div_step) begin
         rem_in  = take ? trial_sub[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
         bin_in  = quot_shift[AW-1:0];
         step_in = step_ff + SW'(1);
      end

      if (cmd.modify) begin
         if (op_ff == OP_ACCUM) begin
            cnt_in = inc_cnt;
            if (inc_cnt > peak_ff) peak_in = inc_cnt;
         end else begin
            cnt_in = rd_ok_ff ? ram_rdata : '0;
         end
      end

      if (cmd.sweep) begin
         sweep_in = sweep_last ? '0 : sweep_ff + AW'(1);
         peak_in  = '0;
      end

      if (cmd.resp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_index_in   = (op_ff == OP_READ) ? rd_addr_ff : bin_wide[IDX_W-1:0];
         rsp_count_in   = cnt_ff;
         rsp_peak_in    = peak_ff;
         rsp_counted_in = hit_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff       <= MIN_RESET;
         max_ff       <= MAX_RESET;
         sel_ff       <= SEL_RESET;
         sweep_ff     <= '0;
         peak_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_ff       <= min_in;
         max_ff       <= max_in;
         sel_ff       <= sel_in;
         sweep_ff     <= sweep_in;
         peak_ff      <= peak_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      hit_ff         <= hit_in;
      rd_ok_ff       <= rd_ok_in;
      rd_addr_ff     <= rd_addr_in;
      bin_ff         <= bin_in;
      cnt_ff         <= cnt_in;
      diff_ff        <= diff_in;
      span_ff        <= span_in;
      num_ff         <= num_in;
      rem_ff         <= rem_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_peak_ff    <= rsp_peak_in;
      rsp_counted_ff <= rsp_counted_in;
   end

   assign status.op         = op_ff;
   assign status.hit        = hit_ff;
   assign status.need_div   = !low_case && !high_case;
   assign status.sweep_last = sweep_last;
   assign status.div_last   = (step_ff == SW'(AW - 1));
   assign status.out_free   = out_free;

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_bin_index  = rsp_index_ff;
   assign rsp_bin_count  = rsp_count_ff;
   assign rsp_peak_count = rsp_peak_ff;
   assign rsp_counted    = rsp_counted_ff;

   `CLH_ASSERT_NOW(a_rem_below_span, clock, reset, cmd.div_step, rem_ff < span_u[SAMPLE_W-1:0])
   `CLH_ASSERT_NOW(a_bin_in_range, clock, reset, cmd.modify && (op_ff == OP_ACCUM), bin_ff <= TOP_BIN)
   `CLH_ASSERT_NEXT(a_peak_covers_bin, clock, reset, cmd.modify && (op_ff == OP_ACCUM), peak_ff >= $past(inc_cnt))

endmodule

[bench/clamped_linear_histogram_core_tb.sv]
`timescale 1ns / 1ps

module clamped_linear_histogram_core_tb;
   import clh_pkg::*;

   localparam int BINS = 1024;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD = 300;
   localparam int TIMEOUT_CYCLES = 600000;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [SAMPLE_W-1:0] sample;
      logic                finite;
      logic [SLOT_W-1:0]   slot;
      logic [IDX_W-1:0]    addr;
      logic                drain_first;
   } hist_req_type;

   typedef struct packed {
      logic [IDX_W-1:0]   bin;
      logic [COUNT_W-1:0] count;
      logic [COUNT_W-1:0] peak;
      logic               counted;
   } hist_rsp_type;

   logic clock;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [SAMPLE_W-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   // Histogram state as the block should hold it, plus its register copies.
   logic [COUNT_W-1:0] bin_tally [BINS] = '{default: '0};
   logic [COUNT_W-1:0] peak_tally = '0;
   logic [SAMPLE_W-1:0] cfg_min = MIN_RESET;
   logic [SAMPLE_W-1:0] cfg_max = MAX_RESET;
   logic [SLOT_W-1:0] cfg_sel = SEL_RESET;

   hist_req_type pending_reqs [$];
   hist_rsp_type expected_hist [$];
   hist_req_type cur_req = '0;

   int errors = 0;
   int req_beats = 0;
   int req_taken = 0;
   int req_gap = 0;
   bit req_busy = 1'b0;
   bit req_fast = 1'b0;
   int rsp_beats = 0;
   int rsp_taken = 0;
   int rsp_wait = 0;
   bit rsp_fast = 1'b0;
   int hold_asks = 0;
   int hold_served = 0;
   int hold_left = 0;

   clamped_linear_histogram_core #(
      .BIN_COUNT(BINS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * TIMEOUT_CYCLES);
      $display("TEST FAILED");
      $finish;
   end

   // Exact bin number: the product fits easily in 64 bits, so no rounding.
   function automatic logic [IDX_W-1:0] bin_of(input logic [SAMPLE_W-1:0] s,
                                                input logic [SAMPLE_W-1:0] lo,
                                                input logic [SAMPLE_W-1:0] hi);
      longint span;
      longint diff;
      longint q;
      span = longint'($signed(hi)) - longint'($signed(lo));
      diff = longint'($signed(s)) - longint'($signed(lo));
      if (span <= 0 || diff <= 0) return '0;
      q = (diff * BINS) / span;
      if (q >= BINS) q = BINS - 1;
      return q[IDX_W-1:0];
   endfunction

   task automatic tally_beat(input hist_req_type it);
      hist_rsp_type r;
      logic [IDX_W-1:0] b;
      r = '0;
      case (it.op)
         OP_ACCUM: begin
            if (it.finite && it.slot == cfg_sel) begin
               b = bin_of(it.sample, cfg_min, cfg_max);
               if (bin_tally[b] != COUNT_MAX) bin_tally[b] = bin_tally[b] + 1'b1;
               if (bin_tally[b] > peak_tally) peak_tally = bin_tally[b];
               r.bin = b;
               r.count = bin_tally[b];
               r.counted = 1'b1;
            end
         end
         OP_READ: begin
            r.bin = it.addr;
            r.count = bin_tally[it.addr];
         end
         OP_CLEAR: begin
            foreach (bin_tally[i]) bin_tally[i] = '0;
            peak_tally = '0;
         end
         default: ;
      endcase
      r.peak = peak_tally;
      expected_hist.push_back(r);
   endtask

   task automatic report_mismatch(input string what);
      errors++;
      $display("%0t ns: %s", $time, what);
   endtask

   task automatic push_req(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] s,
                           input logic fin, input logic [SLOT_W-1:0] slot,
                           input logic [IDX_W-1:0] addr, input logic drain);
      hist_req_type it;
      it.op = op;
      it.sample = s;
      it.finite = fin;
      it.slot = slot;
      it.addr = addr;
      it.drain_first = drain;
      pending_reqs.push_back(it);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         REG_MIN: cfg_min = val;
         REG_MAX: cfg_max = val;
         REG_SEL: cfg_sel = val[SLOT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic settle();
      while (pending_reqs.size() != 0 || req_busy || expected_hist.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(input longint lo, input longint span);
      if (span <= 0) return $urandom;
      return SAMPLE_W'(lo + longint'($urandom) % span);
   endfunction

   task automatic random_config(input int kind);
      logic [SAMPLE_W-1:0] a;
      logic [SAMPLE_W-1:0] b;
      longint top;
      a = $urandom;
      b = $urandom;
      case (kind)
         0: ;
         1: begin
            // Narrow range so that many samples land inside it.
            top = longint'($signed(a)) + (longint'(1) << $urandom_range(10, 24));
            if (top > 64'sd2147483647) top = 64'sd2147483647;
            b = top[SAMPLE_W-1:0];
         end
         2: begin
            if ($signed(a) < $signed(b)) begin
               a = a ^ b;
               b = a ^ b;
               a = a ^ b;
            end
         end
         default: begin
            a = 32'h8000_0000;
            b = 32'h7FFF_FFFF;
         end
      endcase
      write_csr(REG_MIN, a);
      write_csr(REG_MAX, b);
      write_csr(REG_SEL, SAMPLE_W'($urandom_range(0, 15)));
   endtask

   task automatic fill_random(input int n);
      longint lo;
      longint span;
      logic [SAMPLE_W-1:0] hot [4];
      logic [SAMPLE_W-1:0] s;
      logic [OP_W-1:0] op;
      logic [SLOT_W-1:0] slot;
      logic [IDX_W-1:0] addr;
      int r;
      lo = longint'($signed(cfg_min));
      span = longint'($signed(cfg_max)) - lo;
      foreach (hot[i]) hot[i] = pick_sample(lo, span);
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 50) s = pick_sample(lo, span);
         else if (r < 75) s = hot[$urandom_range(0, 3)];
         else if (r < 88)
            s = ($urandom_range(0, 1) ? cfg_min : cfg_max) + SAMPLE_W'($urandom_range(0, 6))
                - SAMPLE_W'(3);
         else s = $urandom;
         r = $urandom_range(0, 199);
         if (r < 140) op = OP_ACCUM;
         else if (r < 190) op = OP_READ;
         else if (r < 196) op = OP_UNUSED;
         else op = OP_CLEAR;
         slot = ($urandom_range(0, 3) != 0) ? cfg_sel : SLOT_W'($urandom_range(0, 15));
         addr = $urandom_range(0, 1) ? bin_of(pick_sample(lo, span), cfg_min, cfg_max)
                                     : IDX_W'($urandom);
         push_req(op, s, $urandom_range(0, 9) != 0, slot, addr, $urandom_range(0, 149) == 0);
      end
   endtask

   // Sender: one item at a time, a random gap before each new beat.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_busy && req_beats != req_taken) begin
            req_taken = req_beats;
            req_busy = 1'b0;
            if ($urandom_range(0, 39) == 0) req_fast = !req_fast;
            req_gap = req_fast ? 0 : $urandom_range(0, 10);
         end
         if (!req_busy) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain_first && expected_hist.size() != 0)) begin
               cur_req = pending_reqs.pop_front();
               req_busy = 1'b1;
            end
         end
      end
      req_tvalid <= req_busy;
      req_tdata <= {2'b00, cur_req.addr, cur_req.slot, cur_req.sample};
      req_tuser <= {cur_req.finite, cur_req.op};
   end

   // Receiver: random waits per result, plus a long hold when one is asked for.
   always @(negedge clock) begin
      bit ready;
      if (rsp_beats != rsp_taken) begin
         rsp_taken = rsp_beats;
         if ($urandom_range(0, 39) == 0) rsp_fast = !rsp_fast;
         rsp_wait = rsp_fast ? 0 : $urandom_range(0, 10);
      end
      if (hold_served != hold_asks) begin
         hold_served = hold_asks;
         hold_left = LONG_HOLD;
      end
      ready = (hold_left == 0 && rsp_wait == 0);
      if (hold_left > 0) hold_left--;
      else if (rsp_wait > 0) rsp_wait--;
      rsp_tready <= ready;
   end

   always @(posedge clock) begin
      hist_rsp_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            tally_beat(cur_req);
            req_beats++;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_beats++;
            if (expected_hist.size() == 0) begin
               report_mismatch("result beat with nothing expected");
            end else begin
               want = expected_hist.pop_front();
               if (rsp_tdata[9:0] !== want.bin)
                  report_mismatch($sformatf("bin_index got %0d want %0d",
                                            rsp_tdata[9:0], want.bin));
               if (rsp_tdata[49:10] !== want.count)
                  report_mismatch($sformatf("bin_count got %0d want %0d",
                                            rsp_tdata[49:10], want.count));
               if (rsp_tdata[89:50] !== want.peak)
                  report_mismatch($sformatf("peak_count got %0d want %0d",
                                            rsp_tdata[89:50], want.peak));
               if (rsp_tuser[0] !== want.counted)
                  report_mismatch($sformatf("counted got %0b want %0b",
                                            rsp_tuser[0], want.counted));
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset range is [0, 1.0) on slot 0.
      push_req(OP_ACCUM, 32'h0000_0000, 1'b1, 4'd0, '0, 1'b0);
      push_req(OP_ACCUM, 32'h0000_8000, 1'b1, 4'd0, '0, 1'b0);
      push_req(OP_ACCUM, 32'h0000_FFFF, 1'b1, 4'd0, '0, 1'b0);
      push_req(OP_ACCUM, 32'h0001_0000, 1'b1, 4'd0, '0, 1'b0);
      push_req(OP_ACCUM, 32'h7FFF_FFFF, 1'b1, 4'd0, '0, 1'b0);
      push_req(OP_ACCUM, 32'h8000_0000, 1'b1, 4'd0, '0, 1'b0);
      push_req(OP_ACCUM, 32'hFFFF_FFFF, 1'b1, 4'd0, '0, 1'b0);
      push_req(OP_ACCUM, 32'h0000_0040, 1'b1, 4'd0, '0, 1'b0);
      push_req(OP_ACCUM, 32'h0000_8000, 1'b0, 4'd0, '0, 1'b0);
      push_req(OP_ACCUM, 32'h0000_8000, 1'b1, 4'd5, '0, 1'b0);
      push_req(OP_READ, '0, 1'b0, 4'd0, 10'd512, 1'b0);
      push_req(OP_READ, '0, 1'b0, 4'd0, 10'd0, 1'b0);
      push_req(OP_READ, '0, 1'b0, 4'd0, 10'd1023, 1'b0);
      push_req(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 4'hF, 10'h3FF, 1'b0);
      push_req(OP_CLEAR, '0, 1'b0, 4'd0, '0, 1'b0);
      push_req(OP_READ, '0, 1'b0, 4'd0, 10'd512, 1'b0);
      push_req(OP_ACCUM, 32'h0000_8000, 1'b1, 4'd0, '0, 1'b1);
      settle();

      // Empty range: both edges at 1.0, then the top below the bottom.
      write_csr(REG_MIN, 32'h0001_0000);
      @(posedge clock);
      push_req(OP_ACCUM, 32'h0001_86A0, 1'b1, 4'd0, '0, 1'b0);
      push_req(OP_ACCUM, 32'hFFFF_FFFB, 1'b1, 4'd0, '0, 1'b0);
      push_req(OP_READ, '0, 1'b0, 4'd0, 10'd0, 1'b0);
      settle();
      write_csr(REG_MAX, 32'hFFFF_0000);
      @(posedge clock);
      push_req(OP_ACCUM, 32'h7FFF_FFFF, 1'b1, 4'd0, '0, 1'b0);
      settle();

      // Widest possible range on the last slot.
      write_csr(REG_MIN, 32'h8000_0000);
      write_csr(REG_MAX, 32'h7FFF_FFFF);
      write_csr(REG_SEL, 32'h0000_000F);
      @(posedge clock);
      push_req(OP_ACCUM, 32'h8000_0000, 1'b1, 4'd15, '0, 1'b0);
      push_req(OP_ACCUM, 32'h7FFF_FFFF, 1'b1, 4'd15, '0, 1'b0);
      push_req(OP_ACCUM, 32'h0000_0000, 1'b1, 4'd15, '0, 1'b0);
      push_req(OP_ACCUM, 32'h0000_0000, 1'b1, 4'd0, '0, 1'b0);
      push_req(OP_READ, '0, 1'b0, 4'd0, 10'd1023, 1'b0);
      settle();

      for (int p = 0; p < 6; p++) begin
         random_config((p + 1) % 4);
         @(posedge clock);
         // In one phase the result side holds off long enough to back up the input.
         if (p == 2) hold_asks++;
         fill_random(230);
         settle();
      end

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[clamped_linear_histogram_core.f]
+incdir+hdl
hdl/clh_pkg.sv
hdl/clh_ram.sv
hdl/clh_ctrl.sv
hdl/clh_datapath.sv
hdl/clamped_linear_histogram_core.sv
bench/clamped_linear_histogram_core_tb.sv
